// ===== sv/buddy_memory_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Shared property forms for the checker of the allocator core.
// ----------------------------------------------------------------------------
`ifndef BUDDY_MEMORY_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_MEMORY_ALLOCATOR_CORE_DEFINES_SVH

// Consequence holds in the same cycle as the antecedent.
`define BAM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");

// Consequence holds in the cycle after the antecedent.
`define BAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");

`endif

// ===== sv/bam_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator package
// Field widths, codes and the order computation shared by the allocator.
// ----------------------------------------------------------------------------
package bam_pkg;

	localparam int ORD_W   = 5;
	localparam int REQ_W   = 16;
	localparam int ADDR_W  = 32;
	localparam int POOL_W  = 13;
	localparam int SIZE_W  = 17;
	localparam int DATA_W  = 32;
	localparam int CIDX_W  = 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CIDX_W-1:0] CFG_POOL_SIZE    = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_BASE_ADDRESS = 1'b1;

	// Order of a byte count rounded up to a power of two; 0 and 1 give order 0.
	function automatic logic [ORD_W-1:0] ceil_log2(input logic [REQ_W-1:0] x);
		logic [REQ_W-1:0] y;
		logic [ORD_W-1:0] n;
		y = x - REQ_W'(1);
		n = '0;
		if (x > REQ_W'(1)) begin
			for (int b = 0; b < REQ_W; b++) begin
				if (y[b]) n = ORD_W'(b + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== sv/bam_req_if.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bam_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [bam_pkg::REQ_W-1:0]   request_size;
	logic [bam_pkg::ADDR_W-1:0]  address;

	modport source (output valid, output operation, output request_size, output address,
		input ready);
	modport sink (input valid, input operation, input request_size, input address,
		output ready);
endinterface

// ===== sv/bam_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bam_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic [bam_pkg::ADDR_W-1:0]  block_address;
	logic [bam_pkg::SIZE_W-1:0]  granted_size;

	modport source (output valid, output ok, output block_address, output granted_size,
		input ready);
	modport sink (input valid, input ok, input block_address, input granted_size,
		output ready);
endinterface

// ===== sv/bam_store.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator free list store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bam_store #(
	parameter int AW = 13,
	parameter int DW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1 << AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/buddy_memory_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Buddy memory allocator core
// Free lists per order live in one store; a sequencer splits and merges.
// ----------------------------------------------------------------------------
// Requests arrive on req (allocate or free), one result per request leaves
// on rsp. Configuration is a plain write port: index 0 sets pool_size and
// rebuilds the lists to one free root block, index 1 sets base_address.
// One request is in work at a time; req is ready only while the sequencer
// is idle. Every list access goes through the single read port of the free
// list store, which has registered read data. An allocate passes over the
// empty orders, takes the head of the first non-empty list, shifts the rest
// of that list down and splits down to the requested order; a free scans
// the list of each order for the buddy, removes a found buddy and merges up
// one order, or else enters the block in that list. Results are held in an
// output register, so the next request is taken while a result waits on a
// stalled receiver; the sequencer only holds a second finished result until
// the first is taken. After reset the block writes the root entry in ST_INIT
// and then takes requests; the reset pool is 4096 bytes (2**MAX_ORDER if
// MAX_ORDER is below 12) at base address zero.
// ----------------------------------------------------------------------------
module buddy_memory_allocator_core #(
	parameter int MAX_ORDER = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bam_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [bam_pkg::DATA_W-1:0]    cfg_data,
	bam_req_if.sink                       req,
	bam_rsp_if.source                     rsp
);

	localparam int AW  = MAX_ORDER + 1;
	localparam int LW  = MAX_ORDER + 1;
	localparam int OW  = MAX_ORDER;
	localparam int OIW = $clog2(MAX_ORDER + 1);
	localparam logic [bam_pkg::ORD_W-1:0] MAXO = bam_pkg::ORD_W'(MAX_ORDER);
	localparam logic [bam_pkg::ORD_W-1:0] RST_TOP = (MAX_ORDER < 12) ? MAXO :
		bam_pkg::ORD_W'(12);

	typedef enum logic [11:0] {
		ST_INIT   = 12'b0000_0000_0001,
		ST_IDLE   = 12'b0000_0000_0010,
		ST_SEARCH = 12'b0000_0000_0100,
		ST_HEAD   = 12'b0000_0000_1000,
		ST_SH_CHK = 12'b0000_0001_0000,
		ST_SH_WR  = 12'b0000_0010_0000,
		ST_SPLIT  = 12'b0000_0100_0000,
		ST_MERGE  = 12'b0000_1000_0000,
		ST_SCAN   = 12'b0001_0000_0000,
		ST_CMP    = 12'b0010_0000_0000,
		ST_MERGED = 12'b0100_0000_0000,
		ST_FINISH = 12'b1000_0000_0000
	} state_t;

	state_t                        state_q;
	logic [bam_pkg::ORD_W-1:0]     top_q;
	logic [bam_pkg::ADDR_W-1:0]    base_q;
	logic [LW-1:0]                 len_q [0:MAX_ORDER];
	logic                          op_q;
	logic [bam_pkg::ORD_W-1:0]     ord_q;
	logic [bam_pkg::ORD_W-1:0]     j_q;
	logic [OW-1:0]                 off_q;
	logic [LW-1:0]                 pos_q;
	logic                          res_ok_q;
	logic [bam_pkg::ADDR_W-1:0]    res_addr_q;
	logic [bam_pkg::SIZE_W-1:0]    res_size_q;
	logic                          out_valid_q;
	logic                          out_ok_q;
	logic [bam_pkg::ADDR_W-1:0]    out_addr_q;
	logic [bam_pkg::SIZE_W-1:0]    out_size_q;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [OW-1:0]                 mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	logic [OW-1:0]                 mem_rdata;

	logic                          accept;
	logic                          pool_wr;
	logic [bam_pkg::ORD_W-1:0]     req_ord;
	logic [bam_pkg::ORD_W-1:0]     cfg_ord;
	logic [bam_pkg::ORD_W-1:0]     new_top;
	logic [bam_pkg::ORD_W-1:0]     jm1;
	logic [LW-1:0]                 jl;
	logic [LW-1:0]                 ol;
	logic [LW-1:0]                 jm1l;
	logic [OW-1:0]                 merge_mask;
	logic [OW-1:0]                 free_off;
	logic [bam_pkg::ADDR_W-1:0]    addr_diff;
	logic                          load_out;

	function automatic logic [AW-1:0] rs(input logic [bam_pkg::ORD_W-1:0] o);
		logic [AW:0] full;
		full = (AW + 1)'(1) << AW;
		return AW'(full - (full >> o));
	endfunction

	function automatic logic [OIW-1:0] li(input logic [bam_pkg::ORD_W-1:0] o);
		return o[OIW-1:0];
	endfunction

	function automatic logic [LW-1:0] cap(input logic [bam_pkg::ORD_W-1:0] o);
		return LW'(1) << (MAXO - o);
	endfunction

	assign accept  = req.valid && req.ready;
	assign pool_wr = cfg_we && (cfg_index == bam_pkg::CFG_POOL_SIZE);
	assign req_ord = bam_pkg::ceil_log2(req.request_size);
	assign cfg_ord = bam_pkg::ceil_log2({3'b000, cfg_data[bam_pkg::POOL_W-1:0]});
	assign new_top = (cfg_ord > MAXO) ? MAXO : cfg_ord;
	assign jm1     = j_q - bam_pkg::ORD_W'(1);
	assign jl      = len_q[li(j_q)];
	assign ol      = len_q[li(ord_q)];
	assign jm1l    = len_q[li(jm1)];
	assign merge_mask = {OW{1'b1}} << (ord_q + bam_pkg::ORD_W'(1));
	assign addr_diff  = req.address - base_q;
	assign free_off   = addr_diff[OW-1:0] & ~({OW{1'b1}} << top_q);
	assign load_out   = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.granted_size  = out_size_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		if (pool_wr) begin
			mem_we    = 1'b1;
			mem_waddr = rs(new_top);
		end else begin
			unique case (state_q)
				ST_INIT: begin
					mem_we    = 1'b1;
					mem_waddr = rs(RST_TOP);
				end
				ST_SEARCH: mem_raddr = rs(j_q);
				ST_SH_CHK: mem_raddr = rs(j_q) + AW'(pos_q) + AW'(1);
				ST_SH_WR: begin
					mem_we    = 1'b1;
					mem_waddr = rs(j_q) + AW'(pos_q);
					mem_wdata = mem_rdata;
				end
				ST_SPLIT: begin
					mem_we    = (j_q > ord_q) && (jm1l < cap(jm1));
					mem_waddr = rs(jm1) + AW'(jm1l);
					mem_wdata = off_q + (OW'(1) << jm1);
				end
				ST_MERGE: begin
					mem_we    = (ord_q == top_q) && (ol < cap(ord_q));
					mem_waddr = rs(ord_q) + AW'(ol);
					mem_wdata = off_q;
				end
				ST_SCAN: begin
					mem_raddr = rs(ord_q) + AW'(pos_q);
					mem_we    = (pos_q >= ol) && (ol < cap(ord_q));
					mem_waddr = rs(ord_q) + AW'(ol);
					mem_wdata = off_q;
				end
				default: begin
				end
			endcase
		end
	end

	bam_store #(
		.AW(AW),
		.DW(OW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			top_q       <= RST_TOP;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			for (int o = 0; o <= MAX_ORDER; o++) begin
				len_q[o] <= (bam_pkg::ORD_W'(o) == RST_TOP) ? LW'(1) : '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_INIT: state_q <= ST_IDLE;
				ST_IDLE: begin
					if (accept) begin
						res_ok_q   <= 1'b0;
						res_addr_q <= '0;
						res_size_q <= '0;
						op_q       <= req.operation;
						ord_q      <= req_ord;
						j_q        <= req_ord;
						off_q      <= free_off;
						if (req_ord > top_q) begin
							state_q <= ST_FINISH;
						end else if (req.operation == bam_pkg::OP_ALLOC) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_MERGE;
						end
					end
				end
				ST_SEARCH: begin
					if (j_q > top_q) begin
						state_q <= ST_FINISH;
					end else if (jl == '0) begin
						j_q <= j_q + bam_pkg::ORD_W'(1);
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					off_q   <= mem_rdata;
					pos_q   <= '0;
					state_q <= ST_SH_CHK;
				end
				// Removal shifts the tail of the list down one entry at a time.
				ST_SH_CHK: begin
					if ((LW + 1)'(pos_q) + (LW + 1)'(1) < (LW + 1)'(jl)) begin
						state_q <= ST_SH_WR;
					end else begin
						len_q[li(j_q)] <= jl - LW'(1);
						state_q <= (op_q == bam_pkg::OP_ALLOC) ? ST_SPLIT : ST_MERGED;
					end
				end
				ST_SH_WR: begin
					pos_q   <= pos_q + LW'(1);
					state_q <= ST_SH_CHK;
				end
				ST_SPLIT: begin
					if (j_q > ord_q) begin
						if (jm1l < cap(jm1)) len_q[li(jm1)] <= jm1l + LW'(1);
						j_q <= jm1;
					end else begin
						res_ok_q   <= 1'b1;
						res_addr_q <= base_q + bam_pkg::ADDR_W'(off_q);
						res_size_q <= bam_pkg::SIZE_W'(1) << ord_q;
						state_q    <= ST_FINISH;
					end
				end
				ST_MERGE: begin
					if (ord_q == top_q) begin
						if (ol < cap(ord_q)) len_q[li(ord_q)] <= ol + LW'(1);
						res_ok_q <= 1'b1;
						state_q  <= ST_FINISH;
					end else begin
						pos_q   <= '0;
						j_q     <= ord_q;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pos_q < ol) begin
						state_q <= ST_CMP;
					end else begin
						if (ol < cap(ord_q)) len_q[li(ord_q)] <= ol + LW'(1);
						res_ok_q <= 1'b1;
						state_q  <= ST_FINISH;
					end
				end
				ST_CMP: begin
					if (((mem_rdata ^ off_q) & merge_mask) == '0) begin
						state_q <= ST_SH_CHK;
					end else begin
						pos_q   <= pos_q + LW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_MERGED: begin
					off_q   <= off_q & merge_mask;
					ord_q   <= ord_q + bam_pkg::ORD_W'(1);
					state_q <= ST_MERGE;
				end
				ST_FINISH: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_INIT;
			endcase

			if (pool_wr) begin
				top_q <= new_top;
				for (int o = 0; o <= MAX_ORDER; o++) begin
					len_q[o] <= (bam_pkg::ORD_W'(o) == new_top) ? LW'(1) : '0;
				end
			end
			if (cfg_we && (cfg_index == bam_pkg::CFG_BASE_ADDRESS)) begin
				base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ok_q   <= res_ok_q;
			out_addr_q <= res_addr_q;
			out_size_q <= res_size_q;
		end
	end

endmodule

// ===== sv/bam_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator port checker
// Watches the request and result channels of the allocator core.
// ----------------------------------------------------------------------------
`include "buddy_memory_allocator_core_defines.svh"

module bam_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_ok,
	input logic [bam_pkg::ADDR_W-1:0]    rsp_block_address,
	input logic [bam_pkg::SIZE_W-1:0]    rsp_granted_size
);

	// A stalled result keeps its payload.
	`BAM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_block_address) && $stable(rsp_granted_size))
	// A failed request returns no block.
	`BAM_ASSERT_SAME(a_fail_zero, clk, arst_n, rsp_valid && !rsp_ok, rsp_block_address == '0 && rsp_granted_size == '0)
	// A result's granted size is zero or one power-of-two block.
	`BAM_ASSERT_SAME(a_size_pow2, clk, arst_n, rsp_valid, $onehot0(rsp_granted_size))
	// Only one request is in work at a time.
	`BAM_ASSERT_NEXT(a_one_busy, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind buddy_memory_allocator_core bam_checker u_bam_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_ok           (rsp.ok),
	.rsp_block_address(rsp.block_address),
	.rsp_granted_size (rsp.granted_size)
);
